>>> rtl/ppdb_pkg.sv
// shared types and constants of the ping-pong double buffer
package ppdb_pkg;

    localparam int BANK_DEPTH_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    localparam int DATA_W  = 64;
    localparam int CAP_W   = 13;
    localparam int CNT_W   = 32;
    localparam int SPACE_W = 13;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select is paddr bit 2 (one 32-bit register at byte address 0)
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_SWAP  = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DATA_W-1:0]   data_word;
        logic                batch_start;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                read_valid;
        logic                write_accepted;
        logic [SPACE_W-1:0]  batch_written;
        logic                overflow_now;
        logic [SPACE_W-1:0]  write_space;
        logic [SPACE_W-1:0]  read_space;
        logic [CNT_W-1:0]    overflow_total;
        logic [CNT_W-1:0]    swap_total;
        logic [CNT_W-1:0]    write_call_total;
        logic [CNT_W-1:0]    read_call_total;
    } t_out_rsp;

endpackage

>>> rtl/ppdb_ram.sv
// generic simple dual-port ram with registered read
module ppdb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ping_pong_double_buffer.sv
// top level of the ping-pong double buffer: banks, positions, batch tracking, stats
// result: a request's result is registered when the request is accepted and is valid in the next cycle
// throughput: one request per cycle while results are taken, set by the single bank
//   ram doing at most one write or one read per request
// reset: synchronous, active low; control state and counters clear at once, the
//   banks are not swept: per-bank fill marks make never-written words read as zero
module ping_pong_double_buffer #(
    parameter int BANK_DEPTH = ppdb_pkg::BANK_DEPTH_DEF,
    parameter int WORD_BITS  = ppdb_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ppdb_pkg::t_in_req                   i_in_req,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ppdb_pkg::t_out_rsp                  o_out_rsp,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppdb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppdb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppdb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ppdb_pkg::*;

    // position width holds 0..BANK_DEPTH, ram address covers both banks
    localparam int PW = $clog2(BANK_DEPTH + 1);
    localparam int RAM_DEPTH = 2 * BANK_DEPTH;
    localparam int RAW = $clog2(RAM_DEPTH);

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    logic [CAP_W-1:0] r_cap;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // zero or oversized capacity falls back to the full bank
    logic [PW-1:0] cap_eff;
    always_comb begin
        if (r_cap == '0 || 32'(r_cap) > 32'(BANK_DEPTH)) begin
            cap_eff = PW'(BANK_DEPTH);
        end else begin
            cap_eff = PW'(r_cap);
        end
    end

    // ---------------------------------------------------------------------
    // state registers
    // ---------------------------------------------------------------------
    logic             r_wsel,   n_wsel;     // bank taking writes, reads use the other
    logic [PW-1:0]    r_wpos,   n_wpos;
    logic [PW-1:0]    r_rpos,   n_rpos;
    logic             r_drop,   n_drop;     // rest of the write batch is dropped
    logic [PW-1:0]    r_bcount, n_bcount;
    logic [CNT_W-1:0] r_ovf_cnt,   n_ovf_cnt;
    logic [CNT_W-1:0] r_swap_cnt,  n_swap_cnt;
    logic [CNT_W-1:0] r_wcall_cnt, n_wcall_cnt;
    logic [CNT_W-1:0] r_rcall_cnt, n_rcall_cnt;
    // fill marks: writes go 0,1,2.. so every word below the mark was written
    logic [PW-1:0]    r_fill [2];
    logic [PW-1:0]    n_fill [2];

    // result registers, read data comes straight from the ram output register
    logic             r_out_valid;
    t_out_rsp         r_rsp,    n_rsp;
    logic             r_rd_hit, n_rd_hit;

    logic             accept_in;
    logic             ram_we, ram_re;
    logic [RAW-1:0]   ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_q;

    // a new request can enter in the cycle its predecessor's result leaves
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept_in  = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------------
    // per-request update: all state moves at the accepting edge
    // ---------------------------------------------------------------------
    always_comb begin
        logic [PW-1:0] bc;
        logic          dr;
        logic          acc;
        logic          ovf_now;
        logic          rvalid;

        n_wsel      = r_wsel;
        n_wpos      = r_wpos;
        n_rpos      = r_rpos;
        n_drop      = r_drop;
        n_bcount    = r_bcount;
        n_ovf_cnt   = r_ovf_cnt;
        n_swap_cnt  = r_swap_cnt;
        n_wcall_cnt = r_wcall_cnt;
        n_rcall_cnt = r_rcall_cnt;
        n_fill      = r_fill;
        n_rd_hit    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        bc          = r_bcount;
        dr          = r_drop;
        acc         = 1'b0;
        ovf_now     = 1'b0;
        rvalid      = 1'b0;

        // bank base plus position
        ram_waddr = r_wsel  ? RAW'(BANK_DEPTH) + RAW'(r_wpos) : RAW'(r_wpos);
        ram_raddr = !r_wsel ? RAW'(BANK_DEPTH) + RAW'(r_rpos) : RAW'(r_rpos);

        unique case (i_in_req.kind)
            K_WRITE: begin
                if (i_in_req.batch_start) begin
                    n_wcall_cnt = r_wcall_cnt + 1'b1;
                    bc = '0;
                    dr = 1'b0;
                end
                if (!dr) begin
                    if (r_wpos >= cap_eff) begin
                        // first refused word of the batch
                        n_ovf_cnt = r_ovf_cnt + 1'b1;
                        dr        = 1'b1;
                        ovf_now   = 1'b1;
                    end else begin
                        ram_we = accept_in;
                        n_wpos = r_wpos + 1'b1;
                        bc     = bc + 1'b1;
                        acc    = 1'b1;
                        if (n_wpos > r_fill[r_wsel]) begin
                            n_fill[r_wsel] = n_wpos;
                        end
                    end
                end
                n_bcount = bc;
                n_drop   = dr;
            end
            K_READ: begin
                if (i_in_req.batch_start) begin
                    n_rcall_cnt = r_rcall_cnt + 1'b1;
                end
                if (r_rpos < cap_eff) begin
                    ram_re   = accept_in;
                    rvalid   = 1'b1;
                    n_rd_hit = r_rpos < r_fill[!r_wsel];
                    n_rpos   = r_rpos + 1'b1;
                end
            end
            K_SWAP: begin
                n_wsel     = !r_wsel;
                n_wpos     = '0;
                n_rpos     = '0;
                n_swap_cnt = r_swap_cnt + 1'b1;
            end
            K_CLEAR: begin
                n_ovf_cnt   = '0;
                n_swap_cnt  = '0;
                n_wcall_cnt = '0;
                n_rcall_cnt = '0;
            end
            default: begin
            end
        endcase

        n_rsp                  = '0;
        n_rsp.read_valid       = rvalid;
        n_rsp.write_accepted   = acc;
        n_rsp.batch_written    = SPACE_W'(n_bcount);
        n_rsp.overflow_now     = ovf_now;
        n_rsp.write_space      = (n_wpos >= cap_eff) ? '0 : SPACE_W'(cap_eff - n_wpos);
        n_rsp.read_space       = (n_rpos >= cap_eff) ? '0 : SPACE_W'(cap_eff - n_rpos);
        n_rsp.overflow_total   = n_ovf_cnt;
        n_rsp.swap_total       = n_swap_cnt;
        n_rsp.write_call_total = n_wcall_cnt;
        n_rsp.read_call_total  = n_rcall_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel      <= 1'b0;
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_drop      <= 1'b0;
            r_bcount    <= '0;
            r_ovf_cnt   <= '0;
            r_swap_cnt  <= '0;
            r_wcall_cnt <= '0;
            r_rcall_cnt <= '0;
            r_fill[0]   <= '0;
            r_fill[1]   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_wsel      <= n_wsel;
                r_wpos      <= n_wpos;
                r_rpos      <= n_rpos;
                r_drop      <= n_drop;
                r_bcount    <= n_bcount;
                r_ovf_cnt   <= n_ovf_cnt;
                r_swap_cnt  <= n_swap_cnt;
                r_wcall_cnt <= n_wcall_cnt;
                r_rcall_cnt <= n_rcall_cnt;
                r_fill      <= n_fill;
            end
            if (accept_in) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_rsp    <= n_rsp;
            r_rd_hit <= n_rd_hit;
        end
    end

    // ---------------------------------------------------------------------
    // bank storage: ram output only changes on an accepted read, so it holds
    // steady while a result waits
    // ---------------------------------------------------------------------
    ppdb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_req.data_word[WORD_BITS-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_out_valid = r_out_valid;

    // words never written since reset read as zero
    always_comb begin
        o_out_rsp = r_rsp;
        if (r_rd_hit) begin
            o_out_rsp.read_data = DATA_W'(ram_q);
        end
    end

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> o_out_valid)
        else $error("no result after an accepted request");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fill[0]) <= 32'(BANK_DEPTH)) && (32'(r_fill[1]) <= 32'(BANK_DEPTH)))
        else $error("bank fill mark beyond bank depth");

    a_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(r_rsp.write_accepted && r_rsp.overflow_now))
        else $error("write both stored and overflowed");

    a_hit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_rd_hit) |-> r_rsp.read_valid)
        else $error("ram data shown on a result without a read");

endmodule
